>>> hdl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants of the counter priority scheduler
// Holds the request and response words, the task table entry layout and the
// table geometry.
// ----------------------------------------------------------------------------
package cps_pkg;

	localparam int TASK_SLOTS = 32;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [4:0] task_index;
		logic       task_present;
		logic       task_ready;
		logic [6:0] task_priority;
		logic [7:0] task_counter;
	} req_t;

	typedef struct packed {
		logic [4:0] current_task;
		logic       switched;
		logic [7:0] current_slice;
		logic       refilled;
		logic       none_runnable;
	} rsp_t;

	typedef struct packed {
		logic       present;
		logic       ready;
		logic [6:0] priority_v;
		logic [7:0] counter;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

endpackage

>>> hdl/counter_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// counter_priority_scheduler_unit: counter based task scheduler
// Task table in one RAM, walked by a small sequencer for ticks and refills.
// ----------------------------------------------------------------------------
// Usage: drive a request word on req and raise start while busy is low; the
// word is taken at that clock edge. Exactly one response word per request
// appears on rsp for one cycle with done high. The receiver cannot stall, so
// it must capture rsp whenever done is high.
// A set-task request writes its entry, then reports via ST_RD and ST_REPORT.
// A tick charges the running task (unless the idle task runs) and, if it must
// reschedule, scans the table from the top slot down to 1, one slot per RAM
// read. If no slot qualifies, a refill pass rewrites every present slot,
// again one slot per cycle, and a second scan follows; the single RAM read
// port sets that pace. The block takes one request at a time.
// Reset clears the per-slot valid bits at once, so every slot reads as empty
// with a zero counter, and the idle task (slot 0) becomes current. No
// clearing pass is needed and start may be raised right after reset.
// ----------------------------------------------------------------------------
module counter_priority_scheduler_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cps_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output cps_pkg::rsp_t rsp
);
	import cps_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RD     = 3'd1;
	localparam logic [2:0] ST_REPORT = 3'd2;
	localparam logic [2:0] ST_DEC    = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_REFILL = 3'd5;

	localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(TASK_SLOTS - 1);
	localparam logic [SLOT_W-1:0] ONE_SLOT = SLOT_W'(1);

	logic [2:0]            state_q;
	logic [TASK_SLOTS-1:0] valid_q;
	logic [SLOT_W-1:0]     run_q;
	logic [SLOT_W-1:0]     ptr_q;
	logic                  iss_q;
	logic                  pass_q;
	logic [SLOT_W-1:0]     best_q;
	logic [7:0]            best_cnt_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic [SLOT_W-1:0]     addr_s1;
	logic                  vld_s1;

	logic                  accept;
	logic                  set_ok;
	logic                  we;
	logic [SLOT_W-1:0]     waddr;
	ent_t                  wdata;
	logic [SLOT_W-1:0]     raddr;
	logic [ENT_W-1:0]      ram_rdata;
	ent_t                  rd_ent;

	logic [7:0]            dec_cnt;
	logic [7:0]            refill_cnt;
	logic                  cand;
	logic [SLOT_W-1:0]     best_nx;
	logic [7:0]            best_cnt_nx;
	logic                  scan_done;
	logic                  refill_done;

	assign accept = start && !busy;
	assign set_ok = (req.task_index != 5'd0) && (32'(req.task_index) < TASK_SLOTS);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Slots never written read as empty entries with a zero counter.
	assign rd_ent = valid_q[addr_s1] ? ent_t'(ram_rdata) : ent_t'('0);

	assign dec_cnt    = (rd_ent.counter != 8'd0) ? rd_ent.counter - 8'd1 : 8'd0;
	assign refill_cnt = {1'b0, rd_ent.counter[7:1]} + {1'b0, rd_ent.priority_v};

	// Strictly greater wins, so on equal counters the higher slot (seen first) stays.
	assign cand        = vld_s1 && rd_ent.present && rd_ent.ready &&
	                     (rd_ent.counter > best_cnt_q);
	assign best_nx     = cand ? addr_s1 : best_q;
	assign best_cnt_nx = cand ? rd_ent.counter : best_cnt_q;
	assign scan_done   = vld_s1 && (addr_s1 == ONE_SLOT);
	assign refill_done = vld_s1 && (addr_s1 == TOP_SLOT);

	assign raddr = ((state_q == ST_SCAN) || (state_q == ST_REFILL)) ? ptr_q : run_q;

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rd_ent;
		unique case (state_q)
			ST_IDLE: begin
				we    = accept && (req.req_type == REQ_SET) && set_ok;
				waddr = SLOT_W'(req.task_index);
				wdata = '{present: req.task_present, ready: req.task_ready,
				          priority_v: req.task_priority, counter: req.task_counter};
			end
			ST_DEC: begin
				we            = 1'b1;
				wdata.counter = dec_cnt;
			end
			ST_REFILL: begin
				we            = vld_s1 && rd_ent.present;
				wdata.counter = refill_cnt;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	cps_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TASK_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(ENT_W'(wdata)),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			run_q      <= '0;
			ptr_q      <= '0;
			iss_q      <= 1'b0;
			pass_q     <= 1'b0;
			best_q     <= '0;
			best_cnt_q <= '0;
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pass_q     <= 1'b0;
						best_q     <= '0;
						best_cnt_q <= '0;
						ptr_q      <= TOP_SLOT;
						iss_q      <= 1'b1;
						if (req.req_type == REQ_SET) begin
							state_q <= ST_RD;
						end else if (run_q == '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DEC: begin
					if (dec_cnt != 8'd0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= iss_q;
					if (iss_q) begin
						if (ptr_q == ONE_SLOT) begin
							iss_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q - ONE_SLOT;
						end
					end
					best_q     <= best_nx;
					best_cnt_q <= best_cnt_nx;
					if (scan_done) begin
						if (best_nx != '0) begin
							run_q   <= best_nx;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else if (!pass_q) begin
							pass_q  <= 1'b1;
							ptr_q   <= ONE_SLOT;
							iss_q   <= 1'b1;
							state_q <= ST_REFILL;
						end else begin
							run_q   <= '0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_REFILL: begin
					vld_s1 <= iss_q;
					if (iss_q) begin
						if (ptr_q == TOP_SLOT) begin
							iss_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q + ONE_SLOT;
						end
					end
					if (refill_done) begin
						ptr_q      <= TOP_SLOT;
						iss_q      <= 1'b1;
						best_q     <= '0;
						best_cnt_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response word; run_q still holds the previous task while it is built.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_REPORT: begin
				rsp_q <= '{current_task: 5'(run_q), switched: 1'b0,
				           current_slice: rd_ent.counter, refilled: 1'b0,
				           none_runnable: 1'b0};
			end
			ST_DEC: begin
				rsp_q <= '{current_task: 5'(run_q), switched: 1'b0,
				           current_slice: dec_cnt, refilled: 1'b0,
				           none_runnable: 1'b0};
			end
			ST_SCAN: begin
				if (best_nx != '0) begin
					rsp_q <= '{current_task: 5'(best_nx), switched: (best_nx != run_q),
					           current_slice: best_cnt_nx, refilled: pass_q,
					           none_runnable: 1'b0};
				end else begin
					rsp_q <= '{current_task: 5'd0, switched: (run_q != '0),
					           current_slice: 8'd0, refilled: 1'b1,
					           none_runnable: 1'b1};
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

endmodule

>>> hdl/cps_ram.sv
// ----------------------------------------------------------------------------
// cps_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> dv/counter_priority_scheduler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counter_priority_scheduler_unit_tb: self-checking bench for the scheduler
// A queue of set-task and tick words feeds a clocked driver with random gaps.
// A scheduler model in the bench predicts each response word, and a clocked
// monitor compares every response word field by field in order.
// ----------------------------------------------------------------------------
module counter_priority_scheduler_unit_tb;
	import cps_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_WORDS = 950;
	localparam int SETTLE_CYCLES = 120;
	localparam int STALL_LIMIT  = 4000;

	typedef struct {
		req_t word;
		bit   drain;
	} pend_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	req_t  req;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	pend_t pending_words[$];
	rsp_t  expected_rsp[$];
	int    error_count;
	int    gap_left;
	int    burst_left;
	int    stall_cycles;

	// Scheduler state as seen by the bench.
	logic       tbl_present[TASK_SLOTS];
	logic       tbl_ready[TASK_SLOTS];
	logic [6:0] tbl_prio[TASK_SLOTS];
	logic [7:0] tbl_count[TASK_SLOTS];
	logic [4:0] cur_slot;

	counter_priority_scheduler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #HALF_PERIOD clk = ~clk;

	// Highest slot wins a tie, so only a strictly larger counter replaces the pick.
	function automatic logic [4:0] pick_slot();
		logic [4:0] best;
		logic [7:0] best_count;
		best = '0;
		best_count = '0;
		for (int i = TASK_SLOTS - 1; i >= 1; i--) begin
			if (tbl_present[i] && tbl_ready[i] && tbl_count[i] > best_count) begin
				best_count = tbl_count[i];
				best = i[4:0];
			end
		end
		return best;
	endfunction

	function automatic rsp_t sched_predict(req_t w);
		rsp_t       r;
		logic [4:0] prev;
		logic [4:0] nxt;
		logic [8:0] sum;
		bit         resched;
		r = '0;
		prev = cur_slot;
		if (w.req_type == REQ_SET) begin
			if (w.task_index != 0) begin
				tbl_present[w.task_index] = w.task_present;
				tbl_ready[w.task_index] = w.task_ready;
				tbl_prio[w.task_index] = w.task_priority;
				tbl_count[w.task_index] = w.task_counter;
			end
		end else begin
			resched = (cur_slot == 0);
			if (cur_slot != 0) begin
				if (tbl_count[cur_slot] != 0)
					tbl_count[cur_slot] = tbl_count[cur_slot] - 8'd1;
				resched = (tbl_count[cur_slot] == 0);
			end
			if (resched) begin
				nxt = pick_slot();
				if (nxt == 0) begin
					for (int i = 1; i < TASK_SLOTS; i++) begin
						if (tbl_present[i]) begin
							sum = {2'b00, tbl_count[i][7:1]} + {2'b00, tbl_prio[i]};
							tbl_count[i] = (sum > 9'd255) ? 8'd255 : sum[7:0];
						end
					end
					r.refilled = 1'b1;
					nxt = pick_slot();
					if (nxt == 0)
						r.none_runnable = 1'b1;
				end
				cur_slot = nxt;
			end
		end
		r.current_task = cur_slot;
		r.switched = (cur_slot != prev);
		r.current_slice = tbl_count[cur_slot];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_set(int idx, bit pres, bit rdy, int prio, int cnt, bit drain = 0);
		pend_t p;
		p.word = '0;
		p.word.req_type = REQ_SET;
		p.word.task_index = idx[4:0];
		p.word.task_present = pres;
		p.word.task_ready = rdy;
		p.word.task_priority = prio[6:0];
		p.word.task_counter = cnt[7:0];
		p.drain = drain;
		pending_words.push_back(p);
	endtask

	task automatic add_tick(bit drain = 0);
		pend_t p;
		p.word = '0;
		p.word.req_type = REQ_TICK;
		p.drain = drain;
		pending_words.push_back(p);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Driver: a word leaves the queue when it is placed on req, and its
	// response is predicted at the edge that takes it.
	always @(posedge clk) begin
		logic start_n;
		req_t req_n;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			start_n = start;
			req_n = req;
			if (start && !busy) begin
				expected_rsp.push_back(sched_predict(req));
				start_n = 1'b0;
				gap_left = pick_gap();
			end
			if (!start_n) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() > 0 &&
						!(pending_words[0].drain && expected_rsp.size() > 0)) begin
					req_n = pending_words[0].word;
					void'(pending_words.pop_front());
					start_n = 1'b1;
				end
			end
			start <= start_n;
			req <= req_n;
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected response word", rsp.current_task, 0);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.current_task !== want.current_task)
					report_mismatch("current_task", rsp.current_task, want.current_task);
				if (rsp.switched !== want.switched)
					report_mismatch("switched", rsp.switched, want.switched);
				if (rsp.current_slice !== want.current_slice)
					report_mismatch("current_slice", rsp.current_slice, want.current_slice);
				if (rsp.refilled !== want.refilled)
					report_mismatch("refilled", rsp.refilled, want.refilled);
				if (rsp.none_runnable !== want.none_runnable)
					report_mismatch("none_runnable", rsp.none_runnable, want.none_runnable);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d words queued and %0d responses owed",
				pending_words.size(), expected_rsp.size());
			$display("[counter_priority_scheduler_unit] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		pend_t p;
		int    r;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		error_count = 0;
		gap_left = 0;
		burst_left = 0;
		stall_cycles = 0;
		cur_slot = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			tbl_present[i] = 1'b0;
			tbl_ready[i] = 1'b0;
			tbl_prio[i] = '0;
			tbl_count[i] = '0;
		end

		// Empty table: the tick refills nothing and falls back to idle.
		add_tick();
		// A write to the idle slot is dropped.
		add_set(0, 1, 1, 127, 255);
		add_tick();
		// Equal full counters: the higher slot is chosen.
		add_set(31, 1, 1, 127, 255);
		add_set(5, 1, 1, 0, 255);
		add_tick();
		add_tick();
		// Set-task while a task runs reports the running task unchanged.
		add_set(31, 1, 1, 127, 0, 1);
		// The running counter is already zero and stays there.
		add_tick();
		// The running slot is removed, yet its counter is still charged.
		add_set(5, 0, 1, 3, 1);
		add_tick();
		// Only present slots are refilled, and the refill yields nothing runnable.
		add_set(31, 1, 0, 0, 1);
		add_set(2, 1, 1, 0, 0);
		add_tick();
		add_tick();
		add_set(1, 1, 1, 127, 255);
		add_set(16, 1, 1, 85, 2);
		add_set(10, 1, 1, 42, 3, 1);
		add_tick();
		add_tick();
		add_set(1, 1, 0, 127, 1);
		add_tick();
		add_tick();
		add_tick();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			p.word = '0;
			p.word.task_index = 5'($urandom_range(0, 31));
			p.word.task_present = ($urandom_range(0, 99) < 85);
			p.word.task_ready = ($urandom_range(0, 99) < 75);
			p.word.task_priority = 7'($urandom_range(0, 127));
			r = $urandom_range(0, 99);
			if (r < 50)
				p.word.task_counter = 8'($urandom_range(0, 6));
			else if (r < 60)
				p.word.task_counter = 8'd255;
			else
				p.word.task_counter = 8'($urandom_range(0, 255));
			// Ticks dominate so that slices run out and rescheduling happens.
			p.word.req_type = ($urandom_range(0, 99) < 65) ? REQ_TICK : REQ_SET;
			p.drain = ($urandom_range(0, 99) < 2);
			pending_words.push_back(p);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_words.size() > 0 || start || expected_rsp.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("[counter_priority_scheduler_unit] OK");
		else
			$display("[counter_priority_scheduler_unit] ERROR");
		$finish;
	end

endmodule
